// ===== sv/wsd_pkg.sv =====
// wsd_pkg: shared types and constants for the websocket frame deframer
// no dependencies; compiled before every other file of the block

package wsd_pkg;

    // width kept for the decoded payload length (16 to 64)
    localparam int LEN_BITS = 32;

    localparam logic [7:0] FIRST_TEXT   = 8'h81;
    localparam logic [7:0] FIRST_BINARY = 8'h82;

    localparam logic [31:0] LEN_FIELD_MASK = 32'h0000_007f;
    localparam logic [6:0]  LEN_EXT16      = 7'd126;
    localparam logic [6:0]  LEN_EXT64      = 7'd127;

    // header byte counts at the end of each length form
    localparam logic [3:0] HDR_AFTER_LEN  = 4'd2;
    localparam logic [3:0] HDR_END_EXT16  = 4'd4;
    localparam logic [3:0] HDR_END_EXT64  = 4'd10;
    localparam logic [3:0] HDR_AFTER_HEAD = 4'd1;

    // full header sizes, mask bytes included
    localparam logic [3:0] HSIZE_SHORT = 4'd6;
    localparam logic [3:0] HSIZE_EXT16 = 4'd8;
    localparam logic [3:0] HSIZE_EXT64 = 4'd14;

    localparam logic [LEN_BITS-1:0] LEN_ONE = LEN_BITS'(1);

    typedef enum logic [1:0] {
        KIND_PAYLOAD   = 2'd0,
        KIND_HEADER    = 2'd1,
        KIND_BAD_START = 2'd2
    } kind_t;

    typedef enum logic [5:0] {
        PH_WAIT    = 6'b000001,
        PH_LEN     = 6'b000010,
        PH_EXT16   = 6'b000100,
        PH_EXT64   = 6'b001000,
        PH_MASK    = 6'b010000,
        PH_PAYLOAD = 6'b100000
    } phase_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        logic        is_binary;
        logic [31:0] payload_length;
        logic [3:0]  header_size;
        logic        last_of_frame;
    } result_t;

    // low 32 bits of the kept length, zero extended when narrower
    function automatic logic [31:0] report_length(input logic [LEN_BITS-1:0] len);
        logic [63:0] wide;
        wide = 64'(len);
        return wide[31:0];
    endfunction

endpackage

// ===== sv/wsd_channels.sv =====
// wsd_in_if / wsd_out_if: valid/ready channels of the deframer
// depends on nothing; payload widths fixed by the frame format

interface wsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

interface wsd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  payload_byte;
    logic        is_binary;
    logic [31:0] payload_length;
    logic [3:0]  header_size;
    logic        last_of_frame;

    modport source (output valid, output result_kind, output payload_byte,
                    output is_binary, output payload_length, output header_size,
                    output last_of_frame, input ready);
    modport sink   (input valid, input result_kind, input payload_byte,
                    input is_binary, input payload_length, input header_size,
                    input last_of_frame, output ready);
endinterface

// ===== sv/wsd_parser.sv =====
// wsd_parser: frame phase tracking, length decode and payload unmasking
// depends on wsd_pkg; one byte handled per accepted transfer

module wsd_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       stream_byte,
    output logic             has_result,
    output wsd_pkg::result_t res
);

    localparam int LB = wsd_pkg::LEN_BITS;

    wsd_pkg::phase_t phase_reg, phase_next;
    logic [3:0]      header_index_reg, header_index_next;
    logic            frame_binary_reg, frame_binary_next;
    logic [LB-1:0]   length_accum_reg, length_accum_next;
    logic [31:0]     mask_key_reg, mask_key_next;
    logic [LB-1:0]   remaining_reg, remaining_next;
    logic [1:0]      mask_pos_reg, mask_pos_next;

    logic [6:0] len_field;
    logic [1:0] byte_sel;
    logic [7:0] key_byte;
    logic       is_last;

    assign len_field = stream_byte[6:0] & wsd_pkg::LEN_FIELD_MASK[6:0];
    // first mask byte sits in the top bits
    assign byte_sel  = 2'd3 - mask_pos_reg;
    assign key_byte  = mask_key_reg[{byte_sel, 3'b000} +: 8];
    assign is_last   = (remaining_reg <= wsd_pkg::LEN_ONE);

    always_comb
    begin
        phase_next        = phase_reg;
        header_index_next = header_index_reg;
        frame_binary_next = frame_binary_reg;
        length_accum_next = length_accum_reg;
        mask_key_next     = mask_key_reg;
        remaining_next    = remaining_reg;
        mask_pos_next     = mask_pos_reg;
        has_result        = 1'b0;
        res               = '0;

        case (phase_reg)
            wsd_pkg::PH_LEN:
            begin
                header_index_next = wsd_pkg::HDR_AFTER_LEN;
                length_accum_next = '0;
                mask_key_next     = '0;
                mask_pos_next     = '0;
                if (len_field == wsd_pkg::LEN_EXT16)
                begin
                    phase_next = wsd_pkg::PH_EXT16;
                end
                else if (len_field == wsd_pkg::LEN_EXT64)
                begin
                    phase_next = wsd_pkg::PH_EXT64;
                end
                else
                begin
                    length_accum_next = LB'(len_field);
                    phase_next        = wsd_pkg::PH_MASK;
                end
            end
            wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64:
            begin
                length_accum_next = {length_accum_reg[LB-9:0], stream_byte};
                header_index_next = header_index_reg + 4'd1;
                if ((phase_reg == wsd_pkg::PH_EXT16 &&
                     header_index_next >= wsd_pkg::HDR_END_EXT16) ||
                    (phase_reg == wsd_pkg::PH_EXT64 &&
                     header_index_next >= wsd_pkg::HDR_END_EXT64))
                begin
                    phase_next = wsd_pkg::PH_MASK;
                end
            end
            wsd_pkg::PH_MASK:
            begin
                mask_key_next     = {mask_key_reg[23:0], stream_byte};
                header_index_next = header_index_reg + 4'd1;
                mask_pos_next     = mask_pos_reg + 2'd1;
                // fourth mask byte closes the header
                if (mask_pos_next == 2'd0)
                begin
                    remaining_next     = length_accum_reg;
                    has_result         = 1'b1;
                    res.kind           = wsd_pkg::KIND_HEADER;
                    res.is_binary      = frame_binary_reg;
                    res.payload_length = wsd_pkg::report_length(length_accum_reg);
                    res.header_size    = header_index_next;
                    if (length_accum_reg == '0)
                    begin
                        phase_next        = wsd_pkg::PH_WAIT;
                        res.last_of_frame = 1'b1;
                    end
                    else
                    begin
                        phase_next = wsd_pkg::PH_PAYLOAD;
                    end
                end
            end
            wsd_pkg::PH_PAYLOAD:
            begin
                mask_pos_next = mask_pos_reg + 2'd1;
                if (remaining_reg != '0)
                begin
                    remaining_next = remaining_reg - wsd_pkg::LEN_ONE;
                end
                if (is_last)
                begin
                    phase_next    = wsd_pkg::PH_WAIT;
                    mask_pos_next = '0;
                end
                has_result        = 1'b1;
                res.kind          = wsd_pkg::KIND_PAYLOAD;
                res.payload_byte  = stream_byte ^ key_byte;
                res.is_binary     = frame_binary_reg;
                res.last_of_frame = is_last;
            end
            default:
            begin
                // waiting for a frame start, stray codes land here too
                phase_next        = wsd_pkg::PH_WAIT;
                header_index_next = '0;
                if (stream_byte == wsd_pkg::FIRST_TEXT ||
                    stream_byte == wsd_pkg::FIRST_BINARY)
                begin
                    frame_binary_next = (stream_byte == wsd_pkg::FIRST_BINARY);
                    header_index_next = wsd_pkg::HDR_AFTER_HEAD;
                    phase_next        = wsd_pkg::PH_LEN;
                end
                else
                begin
                    has_result = 1'b1;
                    res.kind   = wsd_pkg::KIND_BAD_START;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= wsd_pkg::PH_WAIT;
            header_index_reg <= '0;
            frame_binary_reg <= 1'b0;
            length_accum_reg <= '0;
            mask_key_reg     <= '0;
            remaining_reg    <= '0;
            mask_pos_reg     <= '0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            header_index_reg <= header_index_next;
            frame_binary_reg <= frame_binary_next;
            length_accum_reg <= length_accum_next;
            mask_key_reg     <= mask_key_next;
            remaining_reg    <= remaining_next;
            mask_pos_reg     <= mask_pos_next;
        end
    end

    // every byte in the payload phase yields an unmasked byte
    a_payload_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == wsd_pkg::PH_PAYLOAD
        |-> has_result && res.kind == wsd_pkg::KIND_PAYLOAD)
        else $error("payload byte without payload result");

    // header results only carry one of the three legal sizes
    a_header_size: assert property (@(posedge clk) disable iff (!rst_n)
        accept && has_result && res.kind == wsd_pkg::KIND_HEADER
        |-> res.header_size == wsd_pkg::HSIZE_SHORT ||
            res.header_size == wsd_pkg::HSIZE_EXT16 ||
            res.header_size == wsd_pkg::HSIZE_EXT64)
        else $error("bad header size");

    // header result leaves the mask phase
    a_header_exit: assert property (@(posedge clk) disable iff (!rst_n)
        accept && phase_reg == wsd_pkg::PH_MASK && has_result
        |=> phase_reg == wsd_pkg::PH_WAIT || phase_reg == wsd_pkg::PH_PAYLOAD)
        else $error("mask phase not left after header");

endmodule

// ===== sv/wsd_result_reg.sv =====
// wsd_result_reg: output register between the parser and the result channel
// depends on wsd_pkg and wsd_out_if

module wsd_result_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  wsd_pkg::result_t  data,
    output logic              load_ok,
    wsd_out_if.source         result
);

    logic             valid_reg, valid_next;
    wsd_pkg::result_t data_reg;

    // free now, or freed by the transfer taking place this cycle
    assign load_ok = !valid_reg || result.ready;

    always_comb
    begin
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= data;
        end
    end

    assign result.valid          = valid_reg;
    assign result.result_kind    = data_reg.kind;
    assign result.payload_byte   = data_reg.payload_byte;
    assign result.is_binary      = data_reg.is_binary;
    assign result.payload_length = data_reg.payload_length;
    assign result.header_size    = data_reg.header_size;
    assign result.last_of_frame  = data_reg.last_of_frame;

    // never overwrite a result that is still stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !result.ready |-> !push)
        else $error("stalled result overwritten");

    // a loaded result is offered in the next cycle
    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> valid_reg)
        else $error("loaded result not offered");

endmodule

// ===== sv/websocket_frame_deframer.sv =====
// websocket_frame_deframer: top level, client frame receive and unmask
// depends on wsd_pkg, wsd_channels, wsd_parser and wsd_result_reg
//
//   channel   dir   payload                                       transfer
//   stream    in    stream_byte[7:0]                              one frame byte
//   result    out   result_kind, payload_byte, is_binary,         one result
//                   payload_length[31:0], header_size, last_of_frame
//
// one byte per cycle sustained; each accepted byte is decoded in the cycle it
// is taken and its result, if any, appears on result in the next cycle
// throughput is set by the single output register: stream.ready is high
// while that register is empty or being drained by result.ready
// a stall on result holds the stored result and lowers stream.ready
// reset (rst_n low, asynchronous) returns to waiting for a frame start and
// empties the output register; no clearing pass is needed

module websocket_frame_deframer (
    input  logic      clk,
    input  logic      rst_n,
    wsd_in_if.sink    stream,
    wsd_out_if.source result
);

    logic             accept;
    logic             has_result;
    logic             load_ok;
    wsd_pkg::result_t res;

    // bytes flow whenever the output register can take a result
    assign stream.ready = load_ok;
    assign accept       = stream.valid && load_ok;

    // header bytes other than the last mask byte produce no result
    wsd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .stream_byte (stream.stream_byte),
        .has_result  (has_result),
        .res         (res)
    );

    wsd_result_reg u_result_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (accept && has_result),
        .data    (res),
        .load_ok (load_ok),
        .result  (result)
    );

endmodule

// ===== dv/wsd_frame_check.sv =====
// wsd_frame_check: watches both channels of the deframer, predicts its results and compares
// depends on wsd_pkg (types, constants) and wsd_channels (wsd_in_if, wsd_out_if)

module wsd_frame_check (
    input  logic clk,
    input  logic rst_n,
    wsd_in_if    stream,
    wsd_out_if   result,
    output int   mismatches,
    output int   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import wsd_pkg::*;

    // decoder state, reset values
    phase_t              ph        = PH_WAIT;
    logic [3:0]          hdr_count = '0;
    logic                frame_bin = 1'b0;
    logic [LEN_BITS-1:0] len_acc   = '0;
    logic [31:0]         mask_word = '0;
    logic [LEN_BITS-1:0] left_count = '0;
    logic [1:0]          mask_idx  = '0;

    result_t awaited_results[$];
    int      fail_total = 0;
    int      queued     = 0;

    assign mismatches  = fail_total;
    assign outstanding = queued;

    // advance the decoder by one frame byte, queue the result it causes
    task automatic decode_byte(input logic [7:0] b);
        result_t    r;
        logic [6:0] len7;
        int         sh;
        logic       last;
        r = '0;
        case (ph)
            PH_LEN:
            begin
                hdr_count = HDR_AFTER_LEN;
                len7      = b[6:0];
                len_acc   = '0;
                mask_word = '0;
                mask_idx  = '0;
                if (len7 == LEN_EXT16)
                    ph = PH_EXT16;
                else if (len7 == LEN_EXT64)
                    ph = PH_EXT64;
                else
                begin
                    len_acc = LEN_BITS'(len7);
                    ph      = PH_MASK;
                end
            end
            PH_EXT16, PH_EXT64:
            begin
                len_acc   = {len_acc[LEN_BITS-9:0], b};
                hdr_count = hdr_count + 4'd1;
                if ((ph == PH_EXT16 && hdr_count >= HDR_END_EXT16) ||
                    (ph == PH_EXT64 && hdr_count >= HDR_END_EXT64))
                    ph = PH_MASK;
            end
            PH_MASK:
            begin
                mask_word = {mask_word[23:0], b};
                hdr_count = hdr_count + 4'd1;
                mask_idx  = mask_idx + 2'd1;
                if (mask_idx == 2'd0)
                begin
                    left_count       = len_acc;
                    r.kind           = KIND_HEADER;
                    r.is_binary      = frame_bin;
                    r.payload_length = 32'(len_acc);
                    r.header_size    = hdr_count;
                    r.last_of_frame  = (len_acc == '0);
                    ph = (len_acc == '0) ? PH_WAIT : PH_PAYLOAD;
                    awaited_results.push_back(r);
                end
            end
            PH_PAYLOAD:
            begin
                // first mask byte sits in the top bits
                sh       = (3 - int'(mask_idx)) * 8;
                last     = (left_count <= LEN_BITS'(1));
                mask_idx = mask_idx + 2'd1;
                if (left_count != '0)
                    left_count = left_count - LEN_BITS'(1);
                if (last)
                begin
                    ph       = PH_WAIT;
                    mask_idx = '0;
                end
                r.kind          = KIND_PAYLOAD;
                r.payload_byte  = b ^ mask_word[sh +: 8];
                r.is_binary     = frame_bin;
                r.last_of_frame = last;
                awaited_results.push_back(r);
            end
            default:
            begin
                ph        = PH_WAIT;
                hdr_count = '0;
                if (b == FIRST_TEXT || b == FIRST_BINARY)
                begin
                    frame_bin = (b == FIRST_BINARY);
                    hdr_count = HDR_AFTER_HEAD;
                    ph        = PH_LEN;
                end
                else
                begin
                    r.kind = KIND_BAD_START;
                    awaited_results.push_back(r);
                end
            end
        endcase
    endtask

    function automatic int field_diff(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
        if (want === got)
            return 0;
        $display("%0t  %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        return 1;
    endfunction

    // results before bytes: a byte taken at this edge shows its result later
    always @(posedge clk)
    begin : watch
        result_t want;
        if (rst_n)
        begin
            if (result.valid && result.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t  unexpected result: expected none, actual kind %0d",
                             $time, result.result_kind);
                    fail_total++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    fail_total += field_diff("result_kind", want.kind, result.result_kind)
                        + field_diff("payload_byte", want.payload_byte, result.payload_byte)
                        + field_diff("is_binary", want.is_binary, result.is_binary)
                        + field_diff("payload_length", want.payload_length,
                                     result.payload_length)
                        + field_diff("header_size", want.header_size, result.header_size)
                        + field_diff("last_of_frame", want.last_of_frame,
                                     result.last_of_frame);
                end
            end
            if (stream.valid && stream.ready)
                decode_byte(stream.stream_byte);
            queued = awaited_results.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
// testbench: stimulus and verdict for websocket_frame_deframer
// depends on wsd_pkg, wsd_channels, the deframer RTL and wsd_frame_check

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import wsd_pkg::*;

    localparam int RESET_CYCLES  = 12;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int RANDOM_BYTES  = 900;
    localparam int CALM_AFTER    = 750;   // no idling on either side in frames started past this byte count
    localparam int PRESSURE_AT   = 250;
    localparam int PRESSURE_HOLD = 100;
    localparam int TAIL_CYCLES   = 8;

    typedef enum int {FORM_SHORT, FORM_EXT16, FORM_EXT64} len_form_t;

    logic clk;
    logic rst_n;
    int   bytes_sent;
    int   gap_odds;     // 0: sender never idles, else one transfer in gap_odds is delayed
    bit   calm;
    int   mismatches;
    int   outstanding;

    wsd_in_if  stream_ch ();
    wsd_out_if result_ch ();

    websocket_frame_deframer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_ch),
        .result (result_ch)
    );

    wsd_frame_check frame_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .stream      (stream_ch),
        .result      (result_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;
    always #5ns clk = ~clk;

    // offer one byte at a falling edge and hold it until the transfer happens;
    // returns at the next falling edge so the following byte can go straight on
    task automatic push_byte(input logic [7:0] b);
        int idle;
        if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            idle = $urandom_range(1, 4);
            stream_ch.valid <= 1'b0;
            repeat (idle) @(negedge clk);
        end
        stream_ch.valid       <= 1'b1;
        stream_ch.stream_byte <= b;
        do
            @(posedge clk);
        while (!stream_ch.ready);
        @(negedge clk);
        bytes_sent++;
    endtask

    // whole client frame: start byte, length byte (mask bit as given), extended
    // length big endian, four random mask bytes, then body random payload bytes
    task automatic send_frame(input logic binary, input len_form_t form,
                              input logic [63:0] length, input logic mask_bit,
                              input int body);
        push_byte(binary ? FIRST_BINARY : FIRST_TEXT);
        case (form)
            FORM_SHORT:
                push_byte({mask_bit, length[6:0]});
            FORM_EXT16:
            begin
                push_byte({mask_bit, LEN_EXT16});
                push_byte(length[15:8]);
                push_byte(length[7:0]);
            end
            default:
            begin
                push_byte({mask_bit, LEN_EXT64});
                for (int i = 7; i >= 0; i--)
                    push_byte(length[8*i +: 8]);
            end
        endcase
        repeat (4) push_byte(8'($urandom));
        repeat (body) push_byte(8'($urandom));
    endtask

    // watchdog: the slowest correct run is far below this
    initial
    begin : watchdog
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("[websocket_frame_deframer] ERROR");
        $finish;
    end

    // result side: short random stalls in phases, one long hold-off while the
    // sender keeps offering so the output register fills and stream.ready drops
    initial
    begin : result_sink
        int hold;
        int odds;
        bit pressed;
        hold    = 0;
        odds    = 0;
        pressed = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 63) == 0)
                odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
            if (hold > 0)
            begin
                hold--;
                result_ch.ready <= 1'b0;
            end
            else if (!pressed && bytes_sent >= PRESSURE_AT)
            begin
                pressed = 1;
                hold    = PRESSURE_HOLD - 1;
                result_ch.ready <= 1'b0;
            end
            else if (!calm && odds != 0 && $urandom_range(1, odds) == 1)
            begin
                hold = $urandom_range(0, 3);
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // stream side and verdict
    initial
    begin : stimulus
        logic [63:0] len;
        logic [7:0]  noise;
        len_form_t   form;
        int          pick;
        int          n;

        stream_ch.valid       = 1'b0;
        stream_ch.stream_byte = 8'h00;
        rst_n      = 1'b0;
        calm       = 0;
        gap_odds   = 0;
        bytes_sent = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: bad start bytes at both extremes of the byte
        gap_odds = 3;
        push_byte(8'hff);
        push_byte(8'h00);
        // zero length text frame with the mask bit set: header ends the frame
        send_frame(1'b0, FORM_SHORT, 64'd0, 1'b1, 0);
        // binary frame through the 16-bit length form
        send_frame(1'b1, FORM_EXT16, 64'd1, 1'b1, 1);
        // 64-bit length form with high bytes set, which are dropped
        send_frame(1'b0, FORM_EXT64,
                   (LEN_BITS <= 32) ? 64'hffff_ffff_0000_0001 : 64'd1, 1'b0, 1);

        // random: mostly well-formed frames, some stray non-start bytes between them
        while (bytes_sent < RANDOM_BYTES)
        begin
            if (bytes_sent >= CALM_AFTER)
                calm = 1;
            case ($urandom_range(0, 3))
                0:       gap_odds = 0;
                1:       gap_odds = 2;
                default: gap_odds = $urandom_range(3, 10);
            endcase
            pick = $urandom_range(0, 9);
            len  = '0;
            if (pick == 0)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    do
                        noise = 8'($urandom);
                    while (noise == FIRST_TEXT || noise == FIRST_BINARY);
                    push_byte(noise);
                end
            end
            else
            begin
                if (pick < 6)
                begin
                    form = FORM_SHORT;
                    case ($urandom_range(0, 15))
                        0:       n = 125;
                        1, 2, 3: n = $urandom_range(0, 124);
                        default: n = $urandom_range(0, 12);
                    endcase
                end
                else if (pick < 9)
                begin
                    form = FORM_EXT16;
                    n = ($urandom_range(0, 7) == 0) ? $urandom_range(126, 300)
                                                    : $urandom_range(0, 40);
                end
                else
                begin
                    form = FORM_EXT64;
                    n = $urandom_range(0, 20);
                    if (LEN_BITS <= 32)
                        len[63:32] = $urandom;
                end
                len[31:0] = n;
                send_frame(1'($urandom_range(0, 1)), form, len,
                           1'($urandom_range(0, 1)), n);
            end
        end

        // closing frame: largest reportable length, only a few payload bytes sent,
        // so the block is still inside this payload at the end of the run
        send_frame(1'b1, FORM_EXT64, 64'h0000_0000_ffff_ffff, 1'b1, 6);
        stream_ch.valid <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("[websocket_frame_deframer] OK");
        else
            $display("[websocket_frame_deframer] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/wsd_pkg.sv
sv/wsd_channels.sv
sv/wsd_parser.sv
sv/wsd_result_reg.sv
sv/websocket_frame_deframer.sv
dv/wsd_frame_check.sv
dv/testbench.sv
